### sv/sst_pkg.sv
package sst_pkg;

    // operation codes carried in the kind field
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_SPARE  = 2'd3;  // unused, behaves as a query

    // status codes of a result word
    localparam logic [1:0] ST_DONE = 2'd0;  // done or found
    localparam logic [1:0] ST_MISS = 2'd1;  // duplicate on insert, or absent
    localparam logic [1:0] ST_FULL = 2'd2;  // insert refused, store full

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key;
    } sst_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] entry_count;
    } sst_out_t;

    // per-cycle command to every cell of the row
    typedef struct packed {
        logic ins;  // open a slot at the insert point, shift the tail right
        logic rem;  // close the slot at the hit point, shift the tail left
    } sst_op_t;

endpackage

### sv/sst_cell.sv
module sst_cell #(
    parameter int KEY_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sst_pkg::sst_op_t    op,
    input  logic [KEY_BITS-1:0] key,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic                left_valid,
    input  logic                left_lt,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic                right_valid,
    output logic [KEY_BITS-1:0] held_key,
    output logic                held_valid,
    output logic                lt,
    output logic                eq
);
    import sst_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                valid_reg;
    logic                valid_next;

    assign lt = valid_reg && (key_reg < key);
    assign eq = valid_reg && (key_reg == key);

    // cells below the insert/remove point keep their entry
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (op.ins && !lt)
        begin
            if (left_lt)
            begin
                key_next   = key;
                valid_next = 1'b1;
            end
            else
            begin
                key_next   = left_key;
                valid_next = left_valid;
            end
        end
        else if (op.rem && !lt)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign held_key   = key_reg;
    assign held_valid = valid_reg;

endmodule

### sv/sorted_set_table_unit.sv
// channel  | direction | handshake             | word
// ---------+-----------+-----------------------+-------------------------
// command  | in        | start & !busy         | cmd    : kind, key
// result   | out       | done, one-cycle pulse | result : status, entry_count
//
// One command word at a time: the accept edge latches the word, the
// next cycle compares the key in every cell of the row, ORs the match flags
// and shifts the row; the result word is registered and pulses done in the
// cycle after, while busy is already low for the next command.
// Reset clears every cell's valid bit and the entry count at once.
// The result side has no back-pressure; done is never held off.
module sorted_set_table_unit #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sst_pkg::sst_in_t  cmd,
    output logic              done,
    output sst_pkg::sst_out_t result
);
    import sst_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [1:0]           kind_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 done_reg;
    sst_out_t             result_reg;
    sst_out_t             result_next;

    // key taken to KEY_BITS: zero-extended or truncated
    logic [KEY_BITS+15:0] key_wide;
    logic [COUNT_W+4:0]   count_wide;

    logic [KEY_BITS-1:0]  cell_key [CAPACITY];
    logic [CAPACITY-1:0]  cell_valid;
    logic [CAPACITY-1:0]  cell_lt;
    logic [CAPACITY-1:0]  cell_eq;

    logic                 exec;
    logic                 hit;
    logic                 full;
    sst_op_t              op;

    assign key_wide = {{KEY_BITS{1'b0}}, cmd.key};
    assign exec     = (state_reg == S_EXEC);
    assign hit      = |cell_eq;
    assign full     = (count_reg == COUNT_W'(CAPACITY));

    // row command: only during the execute cycle
    assign op = {exec && (kind_reg == KIND_INSERT) && !hit && !full,
                 exec && (kind_reg == KIND_REMOVE) && hit};

    // row of cells, slot 0 holds the smallest key
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_BITS-1:0] lkey;
        logic                lvalid;
        logic                llt;
        logic [KEY_BITS-1:0] rkey;
        logic                rvalid;

        if (i == 0)
        begin : g_first
            // a virtual left neighbor below every key makes slot 0 the
            // insert point when no entry is smaller
            assign lkey   = '0;
            assign lvalid = 1'b0;
            assign llt    = 1'b1;
        end
        else
        begin : g_mid_l
            assign lkey   = cell_key[i-1];
            assign lvalid = cell_valid[i-1];
            assign llt    = cell_lt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rkey   = '0;
            assign rvalid = 1'b0;
        end
        else
        begin : g_mid_r
            assign rkey   = cell_key[i+1];
            assign rvalid = cell_valid[i+1];
        end

        sst_cell #(
            .KEY_BITS(KEY_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .key        (key_reg),
            .left_key   (lkey),
            .left_valid (lvalid),
            .left_lt    (llt),
            .right_key  (rkey),
            .right_valid(rvalid),
            .held_key   (cell_key[i]),
            .held_valid (cell_valid[i]),
            .lt         (cell_lt[i]),
            .eq         (cell_eq[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // status and count of the execute cycle; kind 3 behaves as a query
    always_comb
    begin
        count_next = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (op.rem)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    assign count_wide = {5'b0, count_next};

    always_comb
    begin
        result_next.entry_count = count_wide[4:0];
        if (kind_reg == KIND_INSERT)
        begin
            if (hit)
            begin
                result_next.status = ST_MISS;
            end
            else if (full)
            begin
                result_next.status = ST_FULL;
            end
            else
            begin
                result_next.status = ST_DONE;
            end
        end
        else
        begin
            result_next.status = hit ? ST_DONE : ST_MISS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !exec)
        begin
            kind_reg <= cmd.kind;
            key_reg  <= key_wide[KEY_BITS-1:0];
        end
        if (exec)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = exec;
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // a result word follows an execute cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without a preceding execute cycle");

    // the count matches the number of occupied cells
    a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == count_reg)
        else $error("entry count disagrees with occupied cells");

    // occupied cells form a prefix of the row
    a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + CAPACITY'(1)) & cell_valid) == '0)
        else $error("gap in the row of occupied cells");

    // a refused insert leaves the count alone
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (kind_reg == KIND_INSERT) && full) |=> (count_reg == $past(count_reg)))
        else $error("count changed on an insert into a full store");
`endif

endmodule

### test/sst_checker.sv
`timescale 1ns / 100ps

module sst_checker #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  sst_pkg::sst_in_t  cmd,
    input  logic              done,
    input  sst_pkg::sst_out_t result,
    output int                errors,
    output int                pending,
    output int                results_seen,
    output int                full_refusals,
    output int                empty_misses
);
    import sst_pkg::*;

    // shadow of the table: ascending keys in slots 0 .. key_count-1
    logic [15:0] held_keys [CAPACITY];
    int          key_count;
    sst_out_t    expected_results [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // apply one command word to the shadow table, return the result word
    task automatic apply_cmd(input sst_in_t w, output sst_out_t r);
        int       pos;
        bit       hit;
        logic [1:0] st;
        pos = 0;
        while (pos < key_count && held_keys[pos] < w.key)
            pos++;
        hit = (pos < key_count) && (held_keys[pos] == w.key);
        if (w.kind != KIND_INSERT && key_count == 0)
            empty_misses++;
        case (w.kind)
            KIND_INSERT:
            begin
                if (hit)
                    st = ST_MISS;
                else if (key_count >= CAPACITY)
                begin
                    st = ST_FULL;
                    full_refusals++;
                end
                else
                begin
                    for (int i = key_count; i > pos; i--)
                        held_keys[i] = held_keys[i - 1];
                    held_keys[pos] = w.key;
                    key_count++;
                    st = ST_DONE;
                end
            end
            KIND_REMOVE:
            begin
                if (hit)
                begin
                    for (int i = pos; i + 1 < key_count; i++)
                        held_keys[i] = held_keys[i + 1];
                    key_count--;
                    held_keys[key_count] = '0;
                    st = ST_DONE;
                end
                else
                    st = ST_MISS;
            end
            default:  // query, and the unused code behaves as one
                st = hit ? ST_DONE : ST_MISS;
        endcase
        r.status      = st;
        r.entry_count = 5'(key_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sst_out_t want;
        sst_out_t pred;
        if (!rst_n)
        begin
            foreach (held_keys[i])
                held_keys[i] = '0;
            key_count = 0;
            expected_results.delete();
            errors        = 0;
            results_seen  = 0;
            full_refusals = 0;
            empty_misses  = 0;
        end
        else
        begin
            // check first: a result always belongs to an earlier word
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d/%0d with nothing outstanding",
                                              result.status, result.entry_count));
                else
                begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status got %0d, expected %0d",
                                                  result.status, want.status));
                    if (result.entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count got %0d, expected %0d",
                                                  result.entry_count, want.entry_count));
                end
            end
            if (start && !busy)
            begin
                apply_cmd(cmd, pred);
                expected_results.push_back(pred);
            end
        end
        pending = expected_results.size();
    end

endmodule

### test/tb_sorted_set_table_unit.sv
`timescale 1ns / 100ps

module tb_sorted_set_table_unit;
    import sst_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int N_RANDOM    = 1400;
    localparam int POOL_SIZE   = 20;     // a few more keys than slots, so the table fills
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 4;

    // random phases steer the fill level between empty and full
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    sst_in_t  cmd   = '0;
    logic     done;
    sst_out_t result;

    int errors;
    int pending;
    int results_seen;
    int full_refusals;
    int empty_misses;

    int          cycle_count = 0;
    int          burst_left  = 0;
    bit          steady      = 1'b0;
    int          n_directed  = 0;
    logic [15:0] key_pool [POOL_SIZE];

    sorted_set_table_unit #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (16)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // watches both channels, keeps the shadow table and scores results
    sst_checker #(
        .CAPACITY (CAPACITY)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .done          (done),
        .result        (result),
        .errors        (errors),
        .pending       (pending),
        .results_seen  (results_seen),
        .full_refusals (full_refusals),
        .empty_misses  (empty_misses)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one command word and hold it until the accept edge.
    // Entered and left on a rising edge; start is only raised here, so a
    // back-to-back word never sees start dropped and raised in one step.
    task automatic send_word(input logic [1:0] kind, input logic [15:0] key);
        sst_in_t w;
        w.kind = kind;
        w.key  = key;
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Sender pacing: bursts of random length, random gaps in between.
    // In steady phases the gaps vanish and words go back to back.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    // Hold off until every outstanding result word has come back.
    // The first edge lets the checker book the word accepted just now.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [1:0] pick_kind(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                return (r < 70) ? KIND_INSERT : (r < 85) ? KIND_REMOVE :
                       (r < 97) ? KIND_QUERY : KIND_SPARE;
            MODE_DRAIN:
                return (r < 15) ? KIND_INSERT : (r < 80) ? KIND_REMOVE :
                       (r < 97) ? KIND_QUERY : KIND_SPARE;
            default:
                return (r < 40) ? KIND_INSERT : (r < 75) ? KIND_REMOVE :
                       (r < 97) ? KIND_QUERY : KIND_SPARE;
        endcase
    endfunction

    // mostly pool keys so inserts, removes and queries hit each other;
    // the rest full range so every key bit toggles
    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return 16'($urandom);
    endfunction

    initial
    begin
        int mode;
        int mode_left;

        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        key_pool[2] = 16'h0001;
        key_pool[3] = 16'h8000;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = 16'($urandom);

        // reset, released on a rising edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // empty set: query and remove both miss
        send_word(KIND_QUERY, 16'h0005);
        send_word(KIND_REMOVE, 16'h0005);
        // key extremes, duplicate insert, unused kind as a query on the last entry
        send_word(KIND_INSERT, 16'hFFFF);
        send_word(KIND_INSERT, 16'h0000);
        send_word(KIND_INSERT, 16'h0000);
        send_word(KIND_SPARE, 16'hFFFF);
        send_word(KIND_QUERY, 16'h8000);
        // fill to capacity with keys strictly between the extremes
        for (int i = 1; i <= 14; i++)
            send_word(KIND_INSERT, 16'(i * 16'h1111));
        // full: a new key is refused, a held key still reports duplicate
        send_word(KIND_INSERT, 16'h1234);
        send_word(KIND_INSERT, 16'hFFFF);
        // remove first and last entries, then an absent one
        send_word(KIND_REMOVE, 16'h0000);
        send_word(KIND_REMOVE, 16'hFFFF);
        send_word(KIND_REMOVE, 16'h0000);
        send_word(KIND_QUERY, 16'h8888);
        n_directed = 27;

        wait_idle();

        // ---- random ----
        mode      = MODE_MIXED;
        mode_left = 0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (mode_left == 0)
            begin
                mode      = $urandom_range(MODE_FILL, MODE_MIXED);
                mode_left = $urandom_range(40, 120);
                steady    = ($urandom_range(0, 3) == 0);
            end
            mode_left--;
            if (n % 350 == 349)
                wait_idle();
            pace();
            send_word(pick_kind(mode), pick_key());
        end

        // drain, then idle for TAIL_CYCLES to catch a stray result word
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d directed and %0d random commands, checked %0d results",
                 n_directed, N_RANDOM, results_seen);
        $display("store-full refusals: %0d, misses on an empty set: %0d",
                 full_refusals, empty_misses);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
